>>> rtl/core/frame_reuse_handle_pool_defines.svh
// ----------------------------------------------------------------------------
// frame_reuse_handle_pool_defines
// assertion macros used by the handle pool datapath
// ----------------------------------------------------------------------------
`ifndef FRAME_REUSE_HANDLE_POOL_DEFINES_SVH
`define FRAME_REUSE_HANDLE_POOL_DEFINES_SVH

// same-cycle implication, off during reset
`define FRHP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define FRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/frhp_pkg.sv
// ----------------------------------------------------------------------------
// frhp_pkg
// types and constants shared by the handle pool controller and datapath
// ----------------------------------------------------------------------------
package frhp_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int DESC_BITS_DEF   = 48;
  localparam int GEN_BITS        = 32;
  localparam int TAG_BITS        = 32;
  localparam int SLOT_FIELD_BITS = 4;
  localparam int REQ_BITS        = 2;
  localparam int STATUS_BITS     = 3;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_FRAME   = 2'd0,
    REQ_ACQUIRE = 2'd1,
    REQ_RESOLVE = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_REUSED     = 3'd0,
    ST_CREATED    = 3'd1,
    ST_POOL_FULL  = 3'd2,
    ST_VALID      = 3'd3,
    ST_INVALID    = 3'd4,
    ST_RELEASED   = 3'd5,
    ST_SWEEP_DONE = 3'd6,
    ST_FRAME_SET  = 3'd7
  } status_t;

  typedef struct packed {
    logic    latch;
    logic    idx_init;
    logic    idx_inc;
    logic    addr_req;
    logic    track_dead;
    logic    emit;
    status_t emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic reuse_match;
    logic stale;
    logic idx_last;
    logic found_dead;
    logic res_ok;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/frhp_ram.sv
// ----------------------------------------------------------------------------
// frhp_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module frhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/frhp_ctrl.sv
// ----------------------------------------------------------------------------
// frhp_ctrl
// request sequencer: walks the slot scan and paces result items
// ----------------------------------------------------------------------------
module frhp_ctrl
  import frhp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_BITS-1:0] req_type,
  input  dp_stat_t            stat,
  output dp_cmd_t             cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_FRAME    = 10'b00_0000_0010,
    S_ACQ_RD   = 10'b00_0000_0100,
    S_ACQ_CHK  = 10'b00_0000_1000,
    S_ACQ_NEW  = 10'b00_0001_0000,
    S_RES_RD   = 10'b00_0010_0000,
    S_RES_CHK  = 10'b00_0100_0000,
    S_REL_RD   = 10'b00_1000_0000,
    S_REL_CHK  = 10'b01_0000_0000,
    S_REL_DONE = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.latch    = 1'b1;
          cmd.idx_init = 1'b1;
          case (req_t'(req_type))
            REQ_FRAME:   state_next = S_FRAME;
            REQ_ACQUIRE: state_next = S_ACQ_RD;
            REQ_RESOLVE: state_next = S_RES_RD;
            default:     state_next = S_REL_RD;
          endcase
        end
      end
      S_FRAME: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FRAME_SET;
          state_next      = S_IDLE;
        end
      end
      S_ACQ_RD: begin
        state_next = S_ACQ_CHK;
      end
      S_ACQ_CHK: begin
        cmd.track_dead = 1'b1;
        if (stat.reuse_match) begin
          if (stat.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_REUSED;
            state_next      = S_IDLE;
          end
        end else if (stat.idx_last) begin
          state_next = S_ACQ_NEW;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_ACQ_RD;
        end
      end
      S_ACQ_NEW: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stat.found_dead ? ST_CREATED : ST_POOL_FULL;
          state_next      = S_IDLE;
        end
      end
      S_RES_RD: begin
        cmd.addr_req = 1'b1;
        state_next   = S_RES_CHK;
      end
      S_RES_CHK: begin
        cmd.addr_req = 1'b1;
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stat.res_ok ? ST_VALID : ST_INVALID;
          state_next      = S_IDLE;
        end
      end
      S_REL_RD: begin
        state_next = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (!stat.stale || stat.out_free) begin
          if (stat.stale) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_RELEASED;
          end
          if (stat.idx_last) begin
            state_next = S_REL_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_REL_RD;
          end
        end
      end
      S_REL_DONE: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_SWEEP_DONE;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/frhp_datapath.sv
// ----------------------------------------------------------------------------
// frhp_datapath
// slot tables, scan index, request registers and the result item register
// ----------------------------------------------------------------------------
`include "frame_reuse_handle_pool_defines.svh"

module frhp_datapath
  import frhp_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int DESC_BITS  = DESC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [TAG_BITS-1:0]        frame_tag,
  input  logic [DESC_BITS-1:0]       desc_key,
  input  logic [SLOT_FIELD_BITS-1:0] handle_slot,
  input  logic [GEN_BITS-1:0]        handle_generation,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_BITS-1:0]     status,
  output logic [SLOT_FIELD_BITS-1:0] out_slot,
  output logic [GEN_BITS-1:0]        out_generation,
  output logic                       last_of_run
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);
  localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

  logic [TAG_BITS-1:0]        req_tag;
  logic [DESC_BITS-1:0]       req_key;
  logic [SLOT_FIELD_BITS-1:0] req_slot;
  logic [GEN_BITS-1:0]        req_gen;
  logic [TAG_BITS-1:0]        current_frame;
  logic [SLOT_COUNT-1:0]      slot_alive;
  logic [SLOT_COUNT-1:0]      gen_valid;
  logic [SW-1:0]              idx;
  logic [SW-1:0]              dead_idx;
  logic [GEN_BITS-1:0]        dead_gen;
  logic                       found_dead;

  logic [SW-1:0]        rd_addr;
  logic [GEN_BITS-1:0]  gen_q;
  logic [GEN_BITS-1:0]  gen_rd;
  logic [TAG_BITS-1:0]  lf_q;
  logic [DESC_BITS-1:0] desc_q;
  logic [GEN_BITS-1:0]  new_gen;
  logic                 do_create;
  logic                 do_reuse;
  logic                 do_kill;
  logic                 do_frame;
  logic                 in_range;
  logic                 out_free;
  logic                 lf_we;
  logic [SW-1:0]        lf_waddr;

  assign rd_addr   = cmd.addr_req ? SW'(req_slot) : idx;
  assign do_create = cmd.emit && (cmd.emit_status == ST_CREATED);
  assign do_reuse  = cmd.emit && (cmd.emit_status == ST_REUSED);
  assign do_kill   = cmd.emit && (cmd.emit_status == ST_RELEASED);
  assign do_frame  = cmd.emit && (cmd.emit_status == ST_FRAME_SET);
  assign new_gen   = dead_gen + GEN_BITS'(1);
  assign lf_we     = do_create || do_reuse;
  assign lf_waddr  = do_create ? dead_idx : idx;
  assign out_free  = !out_valid || !out_stall;
  assign in_range  = (req_slot != '0) && (9'(req_slot) < SLOT_LIMIT);

  frhp_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOT_COUNT)) u_gen_ram (
    .clk   (clk),
    .we    (do_create),
    .waddr (dead_idx),
    .wdata (new_gen),
    .raddr (rd_addr),
    .rdata (gen_q)
  );

  frhp_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOT_COUNT)) u_frame_ram (
    .clk   (clk),
    .we    (lf_we),
    .waddr (lf_waddr),
    .wdata (current_frame),
    .raddr (rd_addr),
    .rdata (lf_q)
  );

  frhp_ram #(.WIDTH(DESC_BITS), .DEPTH(SLOT_COUNT)) u_desc_ram (
    .clk   (clk),
    .we    (do_create),
    .waddr (dead_idx),
    .wdata (req_key),
    .raddr (rd_addr),
    .rdata (desc_q)
  );

  // never-written generations read as zero
  assign gen_rd = gen_valid[rd_addr] ? gen_q : '0;

  always_comb begin
    stat.reuse_match = slot_alive[idx] && (lf_q != current_frame) && (desc_q == req_key);
    stat.stale       = slot_alive[idx] && (lf_q != req_tag);
    stat.idx_last    = (idx == LAST_IDX);
    stat.found_dead  = found_dead;
    stat.res_ok      = in_range && slot_alive[rd_addr] && (gen_rd == req_gen);
    stat.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_frame <= '0;
      slot_alive    <= '0;
      gen_valid     <= '0;
      idx           <= SW'(1);
      found_dead    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.idx_init) begin
        idx        <= SW'(1);
        found_dead <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx <= idx + SW'(1);
      end
      if (cmd.track_dead && !found_dead && !slot_alive[idx]) begin
        found_dead <= 1'b1;
      end
      if (do_frame) begin
        current_frame <= req_tag;
      end
      if (do_create) begin
        slot_alive[dead_idx] <= 1'b1;
        gen_valid[dead_idx]  <= 1'b1;
      end
      if (do_kill) begin
        slot_alive[idx] <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_tag  <= frame_tag;
      req_key  <= desc_key;
      req_slot <= handle_slot;
      req_gen  <= handle_generation;
    end
    if (cmd.track_dead && !found_dead && !slot_alive[idx]) begin
      dead_idx <= idx;
      dead_gen <= gen_rd;
    end
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      last_of_run <= (cmd.emit_status != ST_RELEASED);
      case (cmd.emit_status)
        ST_REUSED, ST_RELEASED: begin
          out_slot       <= SLOT_FIELD_BITS'(idx);
          out_generation <= gen_rd;
        end
        ST_CREATED: begin
          out_slot       <= SLOT_FIELD_BITS'(dead_idx);
          out_generation <= new_gen;
        end
        ST_VALID: begin
          out_slot       <= req_slot;
          out_generation <= req_gen;
        end
        default: begin
          out_slot       <= '0;
          out_generation <= '0;
        end
      endcase
    end
  end

  `FRHP_ASSERT_IMPL(a_create_free, do_create, found_dead && !slot_alive[dead_idx], "created slot was live")
  `FRHP_ASSERT_NEXT(a_kill_clears, do_kill, !slot_alive[$past(idx)], "released slot still live")
  `FRHP_ASSERT_IMPL(a_emit_free, cmd.emit, out_free, "result overwrote a waiting item")
  `FRHP_ASSERT_IMPL(a_slot0_dead, 1'b1, !slot_alive[0] && !gen_valid[0], "reserved slot in use")

endmodule

>>> rtl/core/frame_reuse_handle_pool.sv
// ----------------------------------------------------------------------------
// frame_reuse_handle_pool
// pool of slot plus generation handles with per-frame reuse and stale release
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until its last result
// item has been loaded into the output register. Acquire and release scan
// slots 1 to SLOT_COUNT-1 in order, with a read state and a check state for
// each slot, since the slot tables sit in rams with a single registered read
// port; acquire stops at the first reuse match, and released items are
// loaded during the check states. Each request waits while out_stall holds
// a result. Live and written flags sit in flip-flops and clear at reset, so
// no clearing pass is needed.
module frame_reuse_handle_pool
  import frhp_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int DESC_BITS  = DESC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [REQ_BITS-1:0]        req_type,
  input  logic [TAG_BITS-1:0]        frame_tag,
  input  logic [DESC_BITS-1:0]       desc_key,
  input  logic [SLOT_FIELD_BITS-1:0] handle_slot,
  input  logic [GEN_BITS-1:0]        handle_generation,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_BITS-1:0]     status,
  output logic [SLOT_FIELD_BITS-1:0] out_slot,
  output logic [GEN_BITS-1:0]        out_generation,
  output logic                       last_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  frhp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  frhp_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .DESC_BITS  (DESC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .frame_tag         (frame_tag),
    .desc_key          (desc_key),
    .handle_slot       (handle_slot),
    .handle_generation (handle_generation),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .out_slot          (out_slot),
    .out_generation    (out_generation),
    .last_of_run       (last_of_run)
  );

endmodule
